/* hdl/gif_frame_palette_composite_macros.svh */
// Assertion helpers for the top RTL file, gif_frame_palette_composite.sv.
`ifndef GIF_FRAME_PALETTE_COMPOSITE_MACROS_SVH
`define GIF_FRAME_PALETTE_COMPOSITE_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define GFPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define GFPC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/gfpc_pkg.sv */
package gfpc_pkg;

    // input beat kinds (carried on s_tuser)
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_FRAME_LEFT    = 3'd2;
    localparam logic [2:0] CFG_FRAME_TOP     = 3'd3;
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd5;
    localparam logic [2:0] CFG_TRANSPARENT   = 3'd6;
    localparam logic [2:0] CFG_COLOR_COUNT   = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [15:0]       screen_width;
        logic [15:0]       screen_height;
        logic [15:0]       frame_left;
        logic [15:0]       frame_top;
        logic [15:0]       frame_width;
        logic [15:0]       frame_height;
        logic signed [8:0] transparent_index;
        logic [8:0]        color_count;
    } cfg_t;

    // per-pixel result of the raster walk
    typedef struct packed {
        logic [15:0] x;      // screen column, valid when write is set
        logic [15:0] y;      // screen row, valid when write is set
        logic        write;  // on screen, opaque and inside the palette
        logic        last;   // last raster position of the sub-image
    } pix_t;

endpackage

/* hdl/gfpc_ram.sv */
module gfpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/gfpc_raster.sv */
module gfpc_raster #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gfpc_pkg::cfg_t cfg,
    input  logic           step,   // pixel beat accepted
    input  logic [7:0]     color_index,
    output gfpc_pkg::pix_t pix
);

    import gfpc_pkg::*;

    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [16:0] col_inc, row_inc, x_sum, y_sum;
    logic        col_wrap, row_wrap;
    logic        visible, opaque, in_palette;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 17'd1;
        row_inc  = {1'b0, row_reg} + 17'd1;
        col_wrap = col_inc >= {1'b0, cfg.frame_width};
        row_wrap = row_inc >= {1'b0, cfg.frame_height};

        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[15:0];
            end
            else
            begin
                col_next = col_inc[15:0];
            end
        end

        x_sum   = {1'b0, cfg.frame_left} + {1'b0, col_reg};
        y_sum   = {1'b0, cfg.frame_top} + {1'b0, row_reg};
        visible = (x_sum < {1'b0, cfg.screen_width}) && (y_sum < {1'b0, cfg.screen_height});
        // negative transparent index: no transparency
        opaque  = cfg.transparent_index[8] || ({1'b0, color_index} != cfg.transparent_index);
        in_palette = ({1'b0, color_index} < cfg.color_count)
                     && ({24'd0, color_index} < PALETTE_DEPTH);

        pix.x     = x_sum[15:0];
        pix.y     = y_sum[15:0];
        pix.write = visible && opaque && in_palette;
        pix.last  = col_wrap && row_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hdl/gif_frame_palette_composite.sv */
// A pixel beat passes stage 1, stage 2 and the output register to reach m_tdata.
// Throughput: one beat per cycle, loads and pixels alike, while m_tready is high; the
// palette RAM has one write and one read port and each beat uses only one of them.
// Reset: rst_n (async, active low) clears the raster counters, the pipeline valids
// and the config registers (sizes 1, offsets 0, no transparency, color count 0).
// The palette RAM is not cleared; entries must be loaded before use.
module gif_frame_palette_composite #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // color_index, load_red, load_green, load_blue
    input  logic        s_tuser,   // mode: 0 palette load, 1 raster pixel
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // write_address[31:0], red, green, blue, alpha
    output logic        m_tlast    // frame_last
);

    import gfpc_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    cfg_t        cfg_reg;
    pix_t        pix;

    logic        s_accept;
    logic [7:0]  in_index;
    logic        idx_in_depth;
    logic        ram_we, ram_re;
    logic [23:0] ram_rdata;

    // stage 1: raster position resolved, palette read in flight
    logic        s1_v_reg, s1_v_next, s1_adv;
    logic [15:0] s1_x_reg, s1_y_reg;
    logic        s1_last_reg;
    // stage 2: row offset product, palette color captured
    logic        s2_v_reg, s2_v_next, s2_adv;
    logic [31:0] s2_prod_reg;
    logic [15:0] s2_x_reg;
    logic [23:0] s2_rgb_reg;
    logic        s2_last_reg;
    // output register
    logic        out_v_reg, out_v_next, out_adv;
    logic [31:0] out_addr_reg;
    logic [23:0] out_rgb_reg;
    logic        out_last_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width      <= 16'd1;
            cfg_reg.screen_height     <= 16'd1;
            cfg_reg.frame_left        <= 16'd0;
            cfg_reg.frame_top         <= 16'd0;
            cfg_reg.frame_width       <= 16'd1;
            cfg_reg.frame_height      <= 16'd1;
            cfg_reg.transparent_index <= -9'sd1;
            cfg_reg.color_count       <= 9'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width      <= cfg_data;
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height     <= cfg_data;
                CFG_FRAME_LEFT:    cfg_reg.frame_left        <= cfg_data;
                CFG_FRAME_TOP:     cfg_reg.frame_top         <= cfg_data;
                CFG_FRAME_WIDTH:   cfg_reg.frame_width       <= cfg_data;
                CFG_FRAME_HEIGHT:  cfg_reg.frame_height      <= cfg_data;
                CFG_TRANSPARENT:   cfg_reg.transparent_index <= cfg_data[8:0];
                CFG_COLOR_COUNT:   cfg_reg.color_count       <= cfg_data[8:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // ---------------- input side ----------------
    // Each stage moves when the one after it is empty or moving, so bubbles
    // collapse and beats keep coming while a result waits at the output.
    assign out_adv  = !out_v_reg || m_tready;
    assign s2_adv   = !s2_v_reg || out_adv;
    assign s1_adv   = !s1_v_reg || s2_adv;
    assign s_tready = s1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign in_index = s_tdata[7:0];

    assign idx_in_depth = {24'd0, in_index} < PALETTE_DEPTH;

    // A load writes at its accept edge; a pixel beat in the next cycle reads
    // the array after that write, so load-then-use needs no bypass.
    assign ram_we = s_accept && (s_tuser == MODE_LOAD) && idx_in_depth;
    assign ram_re = s_accept && (s_tuser == MODE_PIXEL);

    gfpc_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_index[AW-1:0]),
        .wdata ({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
        .re    (ram_re),
        .raddr (in_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    gfpc_raster #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_raster (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .step        (ram_re),
        .color_index (in_index),
        .pix         (pix)
    );

    // ---------------- pipeline ----------------
    // Only pixels that will be written enter stage 1; everything else drops here.
    assign s1_v_next  = s1_adv ? (ram_re && pix.write) : s1_v_reg;
    assign s2_v_next  = s2_adv ? s1_v_reg : s2_v_reg;
    assign out_v_next = out_adv ? s2_v_reg : out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_x_reg    <= pix.x;
            s1_y_reg    <= pix.y;
            s1_last_reg <= pix.last;
        end
        // RAM read data holds while stage 1 stalls (no read is issued then)
        if (s2_adv)
        begin
            s2_prod_reg <= 32'(s1_y_reg * cfg_reg.screen_width);
            s2_x_reg    <= s1_x_reg;
            s2_rgb_reg  <= ram_rdata;
            s2_last_reg <= s1_last_reg;
        end
        if (out_adv)
        begin
            out_addr_reg <= s2_prod_reg + {16'd0, s2_x_reg};
            out_rgb_reg  <= s2_rgb_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    // ---------------- output side ----------------
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {ALPHA_OPAQUE, out_rgb_reg[7:0], out_rgb_reg[15:8],
                       out_rgb_reg[23:16], out_addr_reg};
    assign m_tlast  = out_last_reg;

`include "gif_frame_palette_composite_macros.svh"

    `GFPC_ASSERT(a_blocked_only_when_full, !s_tready |-> (s1_v_reg && s2_v_reg && out_v_reg), "input blocked with a free stage")
    `GFPC_ASSERT(a_load_gives_no_pixel, (s_accept && s_tuser == MODE_LOAD) |=> !s1_v_reg, "palette load entered the pixel pipe")
    `GFPC_ASSERT(a_s2_holds_on_stall, (s2_v_reg && !s2_adv) |=> (s2_v_reg && $stable(s2_prod_reg)), "stage 2 lost data on stall")
    `GFPC_NEVER(a_ram_one_port_per_beat, ram_we && ram_re, "palette read and write in one beat")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gfpc_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int BEATS_PER_PHASE = 290;
    localparam int SETTLE_CYCLES   = 8;    // pipeline depth is 3, keep some margin
    localparam int HOLD_CYCLES     = 300;

    // one frame buffer write as it should leave the block
    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } fb_write_t;

    // Tracks palette, raster position and registers; queues the writes that must come out.
    class composite_scoreboard;
        cfg_t        regs;
        logic [23:0] palette [256];
        bit          loaded [256];
        logic [15:0] column;
        logic [15:0] row;
        fb_write_t   writes_due [$];
        int          errors;

        function new();
            regs.screen_width      = 16'd1;
            regs.screen_height     = 16'd1;
            regs.frame_left        = 16'd0;
            regs.frame_top         = 16'd0;
            regs.frame_width       = 16'd1;
            regs.frame_height      = 16'd1;
            regs.transparent_index = -9'sd1;
            regs.color_count       = 9'd0;
            column = 16'd0;
            row    = 16'd0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] data);
            case (index)
                CFG_SCREEN_WIDTH:  regs.screen_width      = data;
                CFG_SCREEN_HEIGHT: regs.screen_height     = data;
                CFG_FRAME_LEFT:    regs.frame_left        = data;
                CFG_FRAME_TOP:     regs.frame_top         = data;
                CFG_FRAME_WIDTH:   regs.frame_width       = data;
                CFG_FRAME_HEIGHT:  regs.frame_height      = data;
                CFG_TRANSPARENT:   regs.transparent_index = data[8:0];
                CFG_COLOR_COUNT:   regs.color_count       = data[8:0];
                default: ;
            endcase
        endfunction

        // true when a pixel with this index at the current raster position gets drawn
        function bit reads_palette(logic [7:0] idx);
            logic [16:0] x;
            logic [16:0] y;
            bit          opaque;
            x = {1'b0, regs.frame_left} + {1'b0, column};
            y = {1'b0, regs.frame_top} + {1'b0, row};
            // bit 8 set means a negative index: transparency off
            opaque = regs.transparent_index[8] || (idx != regs.transparent_index[7:0]);
            return (x < {1'b0, regs.screen_width}) && (y < {1'b0, regs.screen_height}) &&
                   opaque && ({1'b0, idx} < regs.color_count);
        endfunction

        function void note_beat(logic mode, logic [7:0] idx, logic [23:0] rgb);
            logic [16:0] x;
            logic [16:0] y;
            logic        col_wrap;
            logic        row_wrap;
            fb_write_t   w;
            if (mode == MODE_LOAD) begin
                palette[idx] = rgb;
                loaded[idx]  = 1'b1;
                return;
            end
            x = {1'b0, regs.frame_left} + {1'b0, column};
            y = {1'b0, regs.frame_top} + {1'b0, row};
            // a zero frame size wraps on every pixel, same as 1
            col_wrap = ({1'b0, column} + 17'd1) >= {1'b0, regs.frame_width};
            row_wrap = ({1'b0, row} + 17'd1) >= {1'b0, regs.frame_height};
            if (reads_palette(idx)) begin
                w.address = 32'(64'(y) * 64'(regs.screen_width) + 64'(x));
                w.red     = palette[idx][23:16];
                w.green   = palette[idx][15:8];
                w.blue    = palette[idx][7:0];
                w.alpha   = ALPHA_OPAQUE;
                w.last    = col_wrap && row_wrap;
                writes_due.push_back(w);
            end
            if (col_wrap) begin
                column = 16'd0;
                row    = row_wrap ? 16'd0 : 16'(row + 16'd1);
            end else begin
                column = 16'(column + 16'd1);
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_write(logic [63:0] data, logic last);
            fb_write_t want;
            if (writes_due.size() == 0) begin
                $error("frame buffer write %h with nothing expected", data);
                errors++;
                return;
            end
            want = writes_due.pop_front();
            compare("write_address", want.address, data[31:0]);
            compare("out_red", want.red, data[39:32]);
            compare("out_green", want.green, data[47:40]);
            compare("out_blue", want.blue, data[55:48]);
            compare("out_alpha", want.alpha, data[63:56]);
            compare("frame_last", want.last, last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_SCREEN_WIDTH;
    logic [15:0] cfg_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;   // color_index, load_red, load_green, load_blue
    logic        s_tuser = MODE_LOAD;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // write_address, red, green, blue, alpha
    logic        m_tlast;           // frame_last

    composite_scoreboard sb = new();

    int feed_idle_pct  = 0;
    int drain_stall_pct = 0;
    bit hold_request   = 1'b0;
    int beats_sent     = 0;
    int cycles         = 0;

    gif_frame_palette_composite dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off when asked for.
    initial
    begin : ready_driver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= drain_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_write(m_tdata, m_tlast);
    end

    // One input beat. Valid stays up after acceptance until the next call or
    // an idle task replaces or lowers it at a falling edge.
    task automatic send_beat(logic mode, logic [7:0] index, logic [23:0] rgb);
        @(negedge clk);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], index};
        do @(posedge clk); while (!s_tready);
        sb.note_beat(mode, index, rgb);
        beats_sent++;
    endtask

    // An entry about to be drawn must hold a loaded color; load it first if not.
    task automatic send_pixel(logic [7:0] index);
        if (sb.reads_palette(index) && !sb.loaded[index])
            send_beat(MODE_LOAD, index, 24'($urandom));
        send_beat(MODE_PIXEL, index, 24'($urandom));
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] data);
        @(negedge clk);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop feeding, wait for every pending write, then let dropped pixels drain.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic maybe_write(logic [2:0] index, logic [15:0] data, bit all);
        if (all || $urandom_range(3) != 0)
            write_reg(index, data);
    endtask

    function automatic logic [7:0] pick_index();
        case ($urandom_range(9))
            0: return sb.regs.transparent_index[7:0];
            1: return 8'(sb.regs.color_count - 9'd1);
            2: return $urandom_range(1) ? 8'hff : 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Picks a new geometry, mostly small; now and then the far corner of the
    // largest screen, a zero screen, a zero frame size or a very long row.
    task automatic random_setup(bit all);
        logic [15:0] sw, sh, fl, ft, fw, fh, ti, cc;
        if ($urandom_range(9) == 0)
        begin
            sw = 16'(65535 - $urandom_range(3));
            sh = 16'(65535 - $urandom_range(3));
            fl = 16'($urandom_range(65511, 65535));
            ft = 16'($urandom_range(65511, 65535));
            fw = 16'($urandom_range(1, 20));
            fh = 16'($urandom_range(1, 4));
        end
        else
        begin
            sw = 16'($urandom_range(1, 24));
            sh = 16'($urandom_range(1, 16));
            fl = $urandom_range(1) ? 16'd0 : 16'($urandom_range(0, sw));
            ft = $urandom_range(1) ? 16'd0 : 16'($urandom_range(0, sh));
            fw = 16'($urandom_range(1, 10));
            fh = 16'($urandom_range(1, 6));
            if ($urandom_range(29) == 0) fw = 16'd0;
            if ($urandom_range(29) == 0) fh = 16'd0;
            if ($urandom_range(39) == 0) sw = 16'd0;
            if ($urandom_range(39) == 0) fw = 16'hffff;
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: ti = 16'hffff;                           // none
            5:             ti = 16'(9'h100 | $urandom_range(255));  // other negatives
            default:       ti = 16'($urandom_range(255));
        endcase
        cc = $urandom_range(1) ? 16'd256 : 16'($urandom_range(256));
        maybe_write(CFG_SCREEN_WIDTH, sw, all);
        maybe_write(CFG_SCREEN_HEIGHT, sh, all);
        maybe_write(CFG_FRAME_LEFT, fl, all);
        maybe_write(CFG_FRAME_TOP, ft, all);
        maybe_write(CFG_FRAME_WIDTH, fw, all);
        maybe_write(CFG_FRAME_HEIGHT, fh, all);
        maybe_write(CFG_TRANSPARENT, ti, all);
        maybe_write(CFG_COLOR_COUNT, cc, all);
    endtask

    // One sub-image: new geometry, then its raster with palette loads mixed in.
    // Some frames are cut short so the next one starts mid-raster.
    task automatic run_frame(bit all);
        int pixels;
        settle();
        random_setup(all);
        pixels = (sb.regs.frame_width == 0 ? 1 : int'(sb.regs.frame_width)) *
                 (sb.regs.frame_height == 0 ? 1 : int'(sb.regs.frame_height));
        if (pixels > 48)
            pixels = 48;
        if ($urandom_range(9) == 0)
            pixels = $urandom_range(1, pixels);
        for (int i = 0; i < pixels; i++)
        begin
            if ($urandom_range(99) < 10)
                send_beat(MODE_LOAD, 8'($urandom_range(255)), 24'($urandom));
            send_pixel(pick_index());
        end
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
                send_beat(MODE_LOAD, 8'($urandom_range(255)), 24'($urandom));
    endtask

    // Full on-screen frame while the output is held off: the pipeline fills
    // and must push back on the input. Partway the feed stops until all
    // writes are out.
    task automatic backpressure_frame();
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd16);
        write_reg(CFG_SCREEN_HEIGHT, 16'd16);
        write_reg(CFG_FRAME_LEFT, 16'd0);
        write_reg(CFG_FRAME_TOP, 16'd0);
        write_reg(CFG_FRAME_WIDTH, 16'd8);
        write_reg(CFG_FRAME_HEIGHT, 16'd8);
        write_reg(CFG_TRANSPARENT, 16'hffff);
        write_reg(CFG_COLOR_COUNT, 16'd256);
        for (int i = 0; i < 256; i += 17)
            send_beat(MODE_LOAD, 8'(i), 24'($urandom));
        hold_request = 1'b1;
        for (int i = 0; i < 64; i++)
        begin
            if (i == 40)
                settle();
            send_pixel(8'((i % 16) * 17));
        end
    endtask

    task automatic directed_checks();
        send_beat(MODE_LOAD, 8'h00, 24'h000000);
        send_beat(MODE_LOAD, 8'hff, 24'hffffff);
        send_beat(MODE_LOAD, 8'h5a, 24'ha55ac3);
        send_pixel(8'h00);                      // color count zero after reset: dropped

        // largest screen, frame at its bottom-right corner: last column and
        // last row fall off the right and bottom edges
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'hffff);
        write_reg(CFG_SCREEN_HEIGHT, 16'hffff);
        write_reg(CFG_FRAME_LEFT, 16'd65534);
        write_reg(CFG_FRAME_TOP, 16'd65533);
        write_reg(CFG_FRAME_WIDTH, 16'd2);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        write_reg(CFG_COLOR_COUNT, 16'd256);
        send_pixel(8'hff);
        send_pixel(8'h00);
        send_pixel(8'h5a);
        send_pixel(8'hff);
        send_pixel(8'h00);
        send_pixel(8'h5a);

        // transparent index 0, frame fully on screen
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd3);
        write_reg(CFG_SCREEN_HEIGHT, 16'd2);
        write_reg(CFG_FRAME_LEFT, 16'd0);
        write_reg(CFG_FRAME_TOP, 16'd0);
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        write_reg(CFG_TRANSPARENT, 16'd0);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'h5a);

        // negative index other than -1 also disables transparency;
        // color count 255 drops index 255
        settle();
        write_reg(CFG_TRANSPARENT, 16'h0100);
        write_reg(CFG_COLOR_COUNT, 16'd255);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'h5a);

        // zero screen width draws nothing; zero frame sizes act like 1
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd0);
        send_pixel(8'h5a);
        settle();
        write_reg(CFG_SCREEN_WIDTH, 16'd4);
        write_reg(CFG_FRAME_WIDTH, 16'd0);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        send_pixel(8'h5a);

        // shrink the frame under a raster already at column 3
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'd4);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h00);
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'd2);
        send_pixel(8'h5a);
        send_pixel(8'h00);
    endtask

    initial
    begin : stimulus
        int src_pct  [4];
        int sink_pct [4];
        int base;
        src_pct  = '{0, 86, 0, 24};
        sink_pct = '{0, 0, 86, 24};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_checks();
        base = beats_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            feed_idle_pct   = src_pct[phase];
            drain_stall_pct = sink_pct[phase];
            if (phase == 0)
                backpressure_frame();
            while (beats_sent < base + BEATS_PER_PHASE * (phase + 1))
                run_frame(phase == 0 && beats_sent == base);
        end

        settle();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
